[rtl/cmdtlv_pkg.sv]
// Shared types, codes and helpers for the command TLV parser.
// No dependencies; the parser unit, core, queue, checker and bench import this package.
`timescale 1ns / 1ps

package cmdtlv_pkg;

   // Parse phase, one-hot
   typedef enum logic [3:0] {
      PH_CMD  = 4'b0001,
      PH_PHDR = 4'b0010,
      PH_DATA = 4'b0100,
      PH_SKIP = 4'b1000
   } phase_type;

   // Result kinds
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_DATA    = 3'd1;
   localparam logic [2:0] KIND_END     = 3'd2;
   localparam logic [2:0] KIND_ZERO    = 3'd3;
   localparam logic [2:0] KIND_OVERRUN = 3'd4;

   // Result queue size: four entries, so a two-result word fits behind two waiting results
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  cmd_ext;
      logic [7:0]  cmd_type;
      logic [15:0] cmd_length;
      logic [31:0] transaction_id;
      logic [7:0]  param_ext;
      logic [7:0]  param_type;
      logic [15:0] param_length;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic        last_in_param;
      logic        last_in_block;
   } rsp_item_type;

   // Up to two results produced by one input word
   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

   // Assemble one result from the current header registers
   function automatic rsp_item_type make_item(
      input logic [2:0]  kind,
      input logic [63:0] block_header,
      input logic [31:0] param_header,
      input logic [7:0]  payload,
      input logic [15:0] idx,
      input logic        lastp,
      input logic        lastb
   );
      rsp_item_type r;
      r.kind           = kind;
      r.cmd_ext        = block_header[63:56];
      r.cmd_type       = block_header[55:48];
      r.cmd_length     = block_header[47:32];
      r.transaction_id = block_header[31:0];
      r.param_ext      = param_header[31:24];
      r.param_type     = param_header[23:16];
      r.param_length   = param_header[15:0];
      r.payload_byte   = payload;
      r.byte_index     = idx;
      r.last_in_param  = lastp;
      r.last_in_block  = lastb;
      return r;
   endfunction

endpackage

[rtl/cmdtlv_req_if.sv]
// Input channel of the command TLV parser: valid/ready plus one stream byte.
// No dependencies.
`timescale 1ns / 1ps

interface cmdtlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_block;

   modport source (output valid, output data_byte, output start_of_block, input ready);
   modport sink (input valid, input data_byte, input start_of_block, output ready);
endinterface

[rtl/cmdtlv_rsp_if.sv]
// Result channel of the command TLV parser: valid/ready plus one result word.
// No dependencies.
`timescale 1ns / 1ps

interface cmdtlv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  cmd_ext;
   logic [7:0]  cmd_type;
   logic [15:0] cmd_length;
   logic [31:0] transaction_id;
   logic [7:0]  param_ext;
   logic [7:0]  param_type;
   logic [15:0] param_length;
   logic [7:0]  payload_byte;
   logic [15:0] byte_index;
   logic        last_in_param;
   logic        last_in_block;

   modport source (
      output valid, output kind, output cmd_ext, output cmd_type, output cmd_length,
      output transaction_id, output param_ext, output param_type, output param_length,
      output payload_byte, output byte_index, output last_in_param, output last_in_block,
      input ready
   );
   modport sink (
      input valid, input kind, input cmd_ext, input cmd_type, input cmd_length,
      input transaction_id, input param_ext, input param_type, input param_length,
      input payload_byte, input byte_index, input last_in_param, input last_in_block,
      output ready
   );
endinterface

[rtl/command_tlv_parser_unit.sv]
// Command TLV parser. Takes one stream byte per clock while req_chan.ready is high
// and emits the command header, each tagged parameter data byte and an end or
// error word for each block that ends or fails. An accepted byte is decoded in
// the same cycle against the parse registers and its results are written into
// the result queue; with the queue empty, the first of them is on the result
// channel on the next cycle. A byte that ends a block (header with an empty
// parameter area, or the last data byte) yields two result words, absorbed by a
// four-entry result queue. req_chan.ready drops only while that queue holds three or more words.
// Uses cmdtlv_pkg, cmdtlv_req_if, cmdtlv_rsp_if, cmdtlv_core, cmdtlv_rsp_queue.
`timescale 1ns / 1ps

module command_tlv_parser_unit (
   input  logic               clock,
   input  logic               reset,
   cmdtlv_req_if.sink         req_chan,
   cmdtlv_rsp_if.source       rsp_chan
);
   import cmdtlv_pkg::*;

   rsp_push_type push;
   rsp_item_type out_item;
   logic         has_room;
   logic         in_accept;

   assign req_chan.ready = has_room;
   assign in_accept      = req_chan.valid && has_room;

   // Decode and parse state
   cmdtlv_core u_core (
      .clock          (clock),
      .reset          (reset),
      .in_accept      (in_accept),
      .data_byte      (req_chan.data_byte),
      .start_of_block (req_chan.start_of_block),
      .push           (push)
   );

   // Result buffering
   cmdtlv_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.kind           = out_item.kind;
   assign rsp_chan.cmd_ext        = out_item.cmd_ext;
   assign rsp_chan.cmd_type       = out_item.cmd_type;
   assign rsp_chan.cmd_length     = out_item.cmd_length;
   assign rsp_chan.transaction_id = out_item.transaction_id;
   assign rsp_chan.param_ext      = out_item.param_ext;
   assign rsp_chan.param_type     = out_item.param_type;
   assign rsp_chan.param_length   = out_item.param_length;
   assign rsp_chan.payload_byte   = out_item.payload_byte;
   assign rsp_chan.byte_index     = out_item.byte_index;
   assign rsp_chan.last_in_param  = out_item.last_in_param;
   assign rsp_chan.last_in_block  = out_item.last_in_block;

endmodule

[rtl/cmdtlv_core.sv]
// Parse state and per-word decode: updates the header/count registers and
// produces up to two result words per accepted input word. Uses cmdtlv_pkg.
`timescale 1ns / 1ps

module cmdtlv_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  logic [7:0]            data_byte,
   input  logic                  start_of_block,
   output cmdtlv_pkg::rsp_push_type push
);
   import cmdtlv_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hcount_ff, hcount_in;
   logic [63:0] bhdr_ff, bhdr_in;
   logic [15:0] remain_ff, remain_in;
   logic [31:0] phdr_ff, phdr_in;
   logic [15:0] pidx_ff, pidx_in;

   phase_type   phase_cur;
   logic [2:0]  hcount_cur;
   logic [63:0] bhdr_cur;
   logic [31:0] phdr_cur;
   logic [15:0] pidx_cur;
   logic [15:0] remain_dec;
   logic [15:0] pidx_inc;
   logic        overran;
   logic        lastp;

   // Decode one word: start flag first, then the phase step
   always_comb begin
      phase_cur  = start_of_block ? PH_CMD : phase_ff;
      hcount_cur = start_of_block ? 3'd0 : hcount_ff;
      bhdr_cur   = start_of_block ? 64'd0 : bhdr_ff;
      phdr_cur   = start_of_block ? 32'd0 : phdr_ff;
      pidx_cur   = start_of_block ? 16'd0 : pidx_ff;

      remain_dec = (remain_ff != 16'd0) ? remain_ff - 16'd1 : 16'd0;
      pidx_inc   = pidx_cur + 16'd1;
      overran    = (hcount_cur == 3'd3) && (remain_ff == 16'd0);
      lastp      = (pidx_inc == phdr_cur[15:0]);

      phase_in  = phase_cur;
      hcount_in = hcount_cur;
      bhdr_in   = bhdr_cur;
      remain_in = remain_ff;
      phdr_in   = phdr_cur;
      pidx_in   = pidx_cur;

      push.push0 = 1'b0;
      push.push1 = 1'b0;
      push.item0 = make_item(KIND_HEADER, bhdr_cur, phdr_cur, 8'd0, 16'd0, 1'b0, 1'b0);
      push.item1 = make_item(KIND_END, bhdr_cur, phdr_cur, 8'd0, 16'd0, 1'b0, 1'b1);

      unique case (phase_cur)
         PH_CMD: begin
            bhdr_in   = {bhdr_cur[55:0], data_byte};
            hcount_in = hcount_cur + 3'd1;
            if (hcount_in == 3'd0) begin
               remain_in  = bhdr_in[47:32];
               phdr_in    = 32'd0;
               pidx_in    = 16'd0;
               push.push0 = 1'b1;
               push.item0 = make_item(KIND_HEADER, bhdr_in, 32'd0, 8'd0, 16'd0,
                                      1'b0, 1'b0);
               push.item1 = make_item(KIND_END, bhdr_in, 32'd0, 8'd0, 16'd0,
                                      1'b0, 1'b1);
               if (remain_in == 16'd0) begin
                  push.push1 = 1'b1;
                  phase_in   = PH_SKIP;
               end else begin
                  phase_in = PH_PHDR;
               end
            end
         end
         PH_PHDR: begin
            phdr_in   = {phdr_cur[23:0], data_byte};
            remain_in = remain_dec;
            hcount_in = {1'b0, hcount_cur[1:0] + 2'd1};
            if (hcount_in == 3'd0) begin
               if (phdr_in[15:0] == 16'd0) begin
                  push.push0 = 1'b1;
                  push.item0 = make_item(KIND_ZERO, bhdr_cur, phdr_in, 8'd0, 16'd0,
                                         1'b0, 1'b1);
                  phase_in   = PH_SKIP;
               end else if (overran || (phdr_in[15:0] > remain_dec)) begin
                  push.push0 = 1'b1;
                  push.item0 = make_item(KIND_OVERRUN, bhdr_cur, phdr_in, 8'd0, 16'd0,
                                         1'b0, 1'b1);
                  phase_in   = PH_SKIP;
               end else begin
                  pidx_in  = 16'd0;
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            push.push0 = 1'b1;
            push.item0 = make_item(KIND_DATA, bhdr_cur, phdr_cur, data_byte, pidx_cur,
                                   lastp, 1'b0);
            remain_in  = remain_dec;
            pidx_in    = pidx_inc;
            if (lastp) begin
               if (remain_dec == 16'd0) begin
                  push.push1 = 1'b1;
                  phase_in   = PH_SKIP;
               end else begin
                  hcount_in = 3'd0;
                  phase_in  = PH_PHDR;
               end
            end
         end
         default: begin
            // skipping: drop the word
         end
      endcase

      if (!in_accept) begin
         push.push0 = 1'b0;
         push.push1 = 1'b0;
      end
   end

   // Advance the parse state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CMD;
         hcount_ff <= 3'd0;
         bhdr_ff   <= 64'd0;
         remain_ff <= 16'd0;
         phdr_ff   <= 32'd0;
         pidx_ff   <= 16'd0;
      end else if (in_accept) begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         bhdr_ff   <= bhdr_in;
         remain_ff <= remain_in;
         phdr_ff   <= phdr_in;
         pidx_ff   <= pidx_in;
      end
   end

endmodule

[rtl/cmdtlv_rsp_queue.sv]
// Small result queue: takes up to two result words a cycle from the decode,
// hands one a cycle to the result channel while it is ready. Uses cmdtlv_pkg.
`timescale 1ns / 1ps

module cmdtlv_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  cmdtlv_pkg::rsp_push_type  push,
   output logic                      has_room,
   output logic                      out_valid,
   input  logic                      out_ready,
   output cmdtlv_pkg::rsp_item_type  out_item
);
   import cmdtlv_pkg::*;

   rsp_item_type            slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]    count_ff, count_in;
   logic [RSP_PTR_W-1:0]    wr_ptr_next;
   logic                    pop;
   logic [RSP_CNT_W-1:0]    push_cnt;

   // Room for a two-result word; pops this cycle are not counted
   assign has_room  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);
      push_cnt    = RSP_CNT_W'(push.push0) + RSP_CNT_W'(push.push1);
      wr_ptr_in   = wr_ptr_ff + RSP_PTR_W'(push_cnt);
      rd_ptr_in   = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in    = count_ff + push_cnt - RSP_CNT_W'(pop);
   end

   // Store result words
   always_ff @(posedge clock) begin
      if (push.push0) begin
         slot_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.push1) begin
         slot_ff[wr_ptr_next] <= push.item1;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/cmdtlv_checker.sv]
// Port-level checks for the command TLV parser, bound to the top level.
// Uses cmdtlv_pkg, cmdtlv_req_if, cmdtlv_rsp_if, command_tlv_parser_unit.
`timescale 1ns / 1ps

module cmdtlv_checker (
   input  logic          clock,
   input  logic          reset,
   cmdtlv_req_if.sink    req_chan,
   cmdtlv_rsp_if.source  rsp_chan
);
   import cmdtlv_pkg::*;

   // Reset empties the result queue
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

   // An empty result side always takes input
   a_room_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled with no pending result");

   // Stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid)
      else $error("result dropped while stalled");

   // Block end flag only on end and error words
   a_last_block_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_in_block |->
         (rsp_chan.kind == KIND_END) || (rsp_chan.kind == KIND_ZERO) ||
         (rsp_chan.kind == KIND_OVERRUN))
      else $error("last_in_block on a non-end word");

   // Only data words carry a parameter position or data byte
   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.kind != KIND_DATA) |->
         (rsp_chan.byte_index == 16'd0) && (rsp_chan.payload_byte == 8'd0) &&
         !rsp_chan.last_in_param)
      else $error("data fields set on a non-data word");

endmodule

bind command_tlv_parser_unit cmdtlv_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

[sim/tb_command_tlv_parser_unit.sv]
// Self-checking bench for command_tlv_parser_unit: random byte streams of well-formed,
// truncated and broken command blocks, each result checked against an in-bench parser.
// Depends on cmdtlv_pkg, cmdtlv_req_if, cmdtlv_rsp_if and the parser RTL.
`timescale 1ns / 1ps

module tb_command_tlv_parser_unit;
   import cmdtlv_pkg::*;

   localparam int TARGET_BYTES = 1050;
   localparam int QUIET_FROM   = 300;
   localparam int QUIET_TO     = 700;
   localparam int HOLD_AT      = 1000;
   localparam int HOLD_LEN     = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [7:0] data;
      logic       sob;
   } stream_byte_type;

   logic clock;
   logic reset;

   cmdtlv_req_if req_if ();
   cmdtlv_rsp_if rsp_if ();

   command_tlv_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Stimulus and scoreboard storage
   stream_byte_type pending_bytes[$];
   rsp_item_type expected_rsp[$];
   int           counted_bytes;
   int           total_bytes;
   int           bytes_taken;
   int           errors;
   int           cyc;
   int           hold_left;
   logic         req_taken;
   int           kind_seen[5];

   // Parser shadow state
   phase_type    parse_phase;
   logic [2:0]   hdr_cnt;
   logic [63:0]  cmd_hdr;
   logic [15:0]  area_left;
   logic [31:0]  par_hdr;
   logic [15:0]  data_pos;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Random idle decision shared by both sides; none inside the quiet window
   function automatic bit take_break();
      if (cyc >= QUIET_FROM && cyc < QUIET_TO)
         return 1'b0;
      return $urandom_range(0, 99) < 31;
   endfunction

   // ---------------------------------------------------------------------
   // Parser shadow
   // ---------------------------------------------------------------------

   // Build one result word from the current header registers
   function automatic rsp_item_type form_result(input logic [2:0] kind, input logic [7:0] payload,
                                                input logic [15:0] idx, input logic lastp,
                                                input logic lastb);
      rsp_item_type r;
      r.kind           = kind;
      r.cmd_ext        = cmd_hdr[63:56];
      r.cmd_type       = cmd_hdr[55:48];
      r.cmd_length     = cmd_hdr[47:32];
      r.transaction_id = cmd_hdr[31:0];
      r.param_ext      = par_hdr[31:24];
      r.param_type     = par_hdr[23:16];
      r.param_length   = par_hdr[15:0];
      r.payload_byte   = payload;
      r.byte_index     = idx;
      r.last_in_param  = lastp;
      r.last_in_block  = lastb;
      return r;
   endfunction

   // Append one predicted result word
   task automatic queue_expected(input rsp_item_type r);
      expected_rsp = {expected_rsp, r};
   endtask

   task automatic reset_parser();
      parse_phase = PH_CMD;
      hdr_cnt     = 3'd0;
      cmd_hdr     = 64'd0;
      area_left   = 16'd0;
      par_hdr     = 32'd0;
      data_pos    = 16'd0;
   endtask

   // Advance the shadow by one accepted word and queue the results it causes
   task automatic parse_word(input logic [7:0] b, input logic sob);
      logic [15:0] plen;
      logic        hdr_over;
      logic        at_end;
      if (sob) begin
         parse_phase = PH_CMD;
         hdr_cnt     = 3'd0;
         cmd_hdr     = 64'd0;
         par_hdr     = 32'd0;
         data_pos    = 16'd0;
      end
      case (parse_phase)
         PH_CMD: begin
            cmd_hdr = {cmd_hdr[55:0], b};
            hdr_cnt = hdr_cnt + 3'd1;
            if (hdr_cnt == 3'd0) begin
               area_left = cmd_hdr[47:32];
               par_hdr   = 32'd0;
               data_pos  = 16'd0;
               queue_expected(form_result(KIND_HEADER, 8'd0, 16'd0, 1'b0, 1'b0));
               if (area_left == 16'd0) begin
                  queue_expected(form_result(KIND_END, 8'd0, 16'd0, 1'b0, 1'b1));
                  parse_phase = PH_SKIP;
               end else begin
                  parse_phase = PH_PHDR;
               end
            end
         end
         PH_PHDR: begin
            hdr_over = (hdr_cnt == 3'd3) && (area_left == 16'd0);
            par_hdr  = {par_hdr[23:0], b};
            if (area_left != 16'd0)
               area_left = area_left - 16'd1;
            hdr_cnt = (hdr_cnt + 3'd1) & 3'd3;
            if (hdr_cnt == 3'd0) begin
               plen = par_hdr[15:0];
               // zero length wins over overrun
               if (plen == 16'd0) begin
                  queue_expected(form_result(KIND_ZERO, 8'd0, 16'd0, 1'b0, 1'b1));
                  parse_phase = PH_SKIP;
               end else if (hdr_over || plen > area_left) begin
                  queue_expected(form_result(KIND_OVERRUN, 8'd0, 16'd0, 1'b0, 1'b1));
                  parse_phase = PH_SKIP;
               end else begin
                  data_pos    = 16'd0;
                  parse_phase = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            plen   = par_hdr[15:0];
            at_end = (data_pos + 16'd1) == plen;
            queue_expected(form_result(KIND_DATA, b, data_pos, at_end, 1'b0));
            if (area_left != 16'd0)
               area_left = area_left - 16'd1;
            data_pos = data_pos + 16'd1;
            if (at_end) begin
               if (area_left == 16'd0) begin
                  queue_expected(form_result(KIND_END, 8'd0, 16'd0, 1'b0, 1'b1));
                  parse_phase = PH_SKIP;
               end else begin
                  hdr_cnt     = 3'd0;
                  parse_phase = PH_PHDR;
               end
            end
         end
         default: ;  // skipping: drop the word
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stream builders
   // ---------------------------------------------------------------------

   task automatic put_byte(input logic [7:0] b, input logic sob, input bit counted);
      stream_byte_type w;
      w.data = b;
      w.sob  = sob;
      pending_bytes = {pending_bytes, w};
      if (counted)
         counted_bytes++;
   endtask

   task automatic put_cmd_header(input logic [7:0] ext, input logic [7:0] typ,
                                 input logic [15:0] len, input logic [31:0] id);
      put_byte(ext, 1'b1, 1'b1);
      put_byte(typ, 1'b0, 1'b1);
      put_byte(len[15:8], 1'b0, 1'b1);
      put_byte(len[7:0], 1'b0, 1'b1);
      put_byte(id[31:24], 1'b0, 1'b1);
      put_byte(id[23:16], 1'b0, 1'b1);
      put_byte(id[15:8], 1'b0, 1'b1);
      put_byte(id[7:0], 1'b0, 1'b1);
   endtask

   task automatic put_param_header(input logic [7:0] ext, input logic [7:0] typ,
                                   input logic [15:0] len);
      put_byte(ext, 1'b0, 1'b1);
      put_byte(typ, 1'b0, 1'b1);
      put_byte(len[15:8], 1'b0, 1'b1);
      put_byte(len[7:0], 1'b0, 1'b1);
   endtask

   task automatic put_data(input int n);
      for (int i = 0; i < n; i++)
         put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Trailing bytes after a block end; the parser skips them
   task automatic put_noise(input int n);
      for (int i = 0; i < n; i++)
         put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
   endtask

   task automatic put_cmd_random(input logic [15:0] len);
      put_cmd_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, $urandom);
   endtask

   task automatic put_param_random(input logic [15:0] len);
      put_param_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
   endtask

   task automatic build_stimulus();
      int sel;
      int nparam;
      int lens[3];
      int area;
      int good_len;
      int extra;
      // Directed: empty area, area exhausted on a data byte, zero-length parameter
      put_cmd_header(8'hFF, 8'h00, 16'h0000, 32'hFFFF_FFFF);
      put_cmd_header(8'h00, 8'hFF, 16'd5, 32'h0000_0000);
      put_param_header(8'hFF, 8'h00, 16'd1);
      put_byte(8'hFF, 1'b0, 1'b1);
      put_noise(1);
      put_cmd_header(8'h5A, 8'hA5, 16'hFFFF, 32'h8000_0001);
      put_param_header(8'h12, 8'h34, 16'h0000);

      while (counted_bytes < TARGET_BYTES) begin
         sel      = $urandom_range(0, 99);
         good_len = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 4) : 0;
         if (sel < 60) begin
            // well-formed block, mostly short parameters
            nparam = $urandom_range(1, 3);
            area   = 0;
            for (int i = 0; i < nparam; i++) begin
               lens[i] = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 120)
                                                      : $urandom_range(1, 6);
               area += 4 + lens[i];
            end
            put_cmd_random(16'(area));
            for (int i = 0; i < nparam; i++) begin
               put_param_random(16'(lens[i]));
               put_data(lens[i]);
            end
            put_noise($urandom_range(0, 2));
         end else if (sel < 70) begin
            // zero-length parameter ends the block early
            area = (good_len != 0 ? 4 + good_len : 0) + 4 + $urandom_range(0, 10);
            put_cmd_random(16'(area));
            if (good_len != 0) begin
               put_param_random(16'(good_len));
               put_data(good_len);
            end
            put_param_random(16'h0000);
            put_noise($urandom_range(0, 2));
         end else if (sel < 80) begin
            // parameter length larger than the area left
            extra = $urandom_range(0, 8);
            area  = (good_len != 0 ? 4 + good_len : 0) + 4 + extra;
            put_cmd_random(16'(area));
            if (good_len != 0) begin
               put_param_random(16'(good_len));
               put_data(good_len);
            end
            put_param_random(($urandom_range(0, 4) == 0) ? 16'hFFFF
                                : 16'(extra + 1 + $urandom_range(0, 30)));
            put_noise($urandom_range(0, 2));
         end else if (sel < 88) begin
            // parameter header runs past the end of the area
            area = (good_len != 0 ? 4 + good_len : 0) + $urandom_range(1, 3);
            put_cmd_random(16'(area));
            if (good_len != 0) begin
               put_param_random(16'(good_len));
               put_data(good_len);
            end
            put_param_random(16'($urandom_range(1, 65535)));
            put_noise($urandom_range(0, 2));
         end else if (sel < 95) begin
            // block cut short by the next start flag, random header content
            extra = $urandom_range(1, 40);
            put_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            put_data(extra - 1);
         end else begin
            // raw noise with stray start flags
            extra = $urandom_range(1, 12);
            for (int i = 0; i < extra; i++)
               put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0, 1'b1);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: present words at the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      stream_byte_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_bytes.size() != 0 && !take_break()) begin
            w = pending_bytes.pop_front();
            req_if.valid          <= 1'b1;
            req_if.data_byte      <= w.data;
            req_if.start_of_block <= w.sob;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result ready: random stalls, plus one long hold to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (cyc == HOLD_AT) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= HOLD_LEN;
      end else begin
         rsp_if.ready <= !take_break();
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ---------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                  exp_val, act_val);
         errors++;
      end
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_rsp.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual kind %0d", $realtime,
                  got.kind);
         errors++;
      end else begin
         want = expected_rsp.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("cmd_ext", 32'(want.cmd_ext), 32'(got.cmd_ext));
         compare_field("cmd_type", 32'(want.cmd_type), 32'(got.cmd_type));
         compare_field("cmd_length", 32'(want.cmd_length), 32'(got.cmd_length));
         compare_field("transaction_id", want.transaction_id, got.transaction_id);
         compare_field("param_ext", 32'(want.param_ext), 32'(got.param_ext));
         compare_field("param_type", 32'(want.param_type), 32'(got.param_type));
         compare_field("param_length", 32'(want.param_length), 32'(got.param_length));
         compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
         compare_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
         compare_field("last_in_param", 32'(want.last_in_param), 32'(got.last_in_param));
         compare_field("last_in_block", 32'(want.last_in_block), 32'(got.last_in_block));
         if (want.kind <= KIND_OVERRUN)
            kind_seen[want.kind]++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      cyc       <= cyc + 1;
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         parse_word(req_if.data_byte, req_if.start_of_block);
         bytes_taken++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind           = rsp_if.kind;
         got.cmd_ext        = rsp_if.cmd_ext;
         got.cmd_type       = rsp_if.cmd_type;
         got.cmd_length     = rsp_if.cmd_length;
         got.transaction_id = rsp_if.transaction_id;
         got.param_ext      = rsp_if.param_ext;
         got.param_type     = rsp_if.param_type;
         got.param_length   = rsp_if.param_length;
         got.payload_byte   = rsp_if.payload_byte;
         got.byte_index     = rsp_if.byte_index;
         got.last_in_param  = rsp_if.last_in_param;
         got.last_in_block  = rsp_if.last_in_block;
         check_result(got);
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: reset, run the stream, drain, report
   // ---------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.data_byte      = 8'd0;
      req_if.start_of_block = 1'b0;
      rsp_if.ready          = 1'b0;
      cyc                   = 0;
      hold_left             = 0;
      req_taken             = 1'b0;
      counted_bytes         = 0;
      bytes_taken           = 0;
      errors                = 0;
      for (int k = 0; k < 5; k++)
         kind_seen[k] = 0;
      reset_parser();
      build_stimulus();
      total_bytes = pending_bytes.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_taken < total_bytes)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d stream words in %0d cycles: %0d headers, %0d data words,",
               bytes_taken, cyc, kind_seen[KIND_HEADER], kind_seen[KIND_DATA]);
      $display("  %0d normal ends, %0d zero-length ends and %0d overruns checked.",
               kind_seen[KIND_END], kind_seen[KIND_ZERO], kind_seen[KIND_OVERRUN]);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
